FILE: rtl/gbka_pkg.sv
package gbka_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_OBJECT = 2'd0,
      CMD_NATIVE = 2'd1,
      CMD_REPORT = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ORDER_COUNT   = 2'd0,
      ORDER_SHALLOW = 2'd1,
      ORDER_NATIVE  = 2'd2,
      ORDER_NONE    = 2'd3
   } order_type;

   localparam logic [7:0] REG_ORDER_MODE   = 8'd0;
   localparam logic [7:0] REG_REPORT_COUNT = 8'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REC_SCAN,
      ST_TOT_SCAN,
      ST_TOT_EMIT,
      ST_RANK_SCAN,
      ST_RANK_EMIT
   } state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] count;
      logic [47:0] shallow;
      logic [47:0] native;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic        kind;
      logic [31:0] key;
      logic [31:0] count;
      logic [47:0] shallow;
      logic [47:0] native;
      logic        overflow;
      logic        last;
   } row_type;

   // saturating adds
   function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? MAX48 : s[47:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? MAX32 : s[31:0];
   endfunction

endpackage

FILE: rtl/group_by_key_aggregate_top_n.sv
// Per-key aggregate table with a top-N report. Entries live in a single-port-read,
// single-port-write RAM of TABLE_DEPTH rows; valid bits are flip-flops. Every record with
// a nonzero key scans the table through the RAM read port, one entry a cycle. A miss
// scans the whole table; a hit ends the scan early. A report makes one totals pass and
// emits the totals row, then makes one pass and one emit per ranked row; each emit
// waits until the output register is free.
// One item is in work at a time; req_ready is high only between items.
// Configuration writes are always accepted and must come while the block is idle.
module group_by_key_aggregate_top_n (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_class_key,
   input  logic [31:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_row_kind,
   output logic [31:0] rsp_row_key,
   output logic [31:0] rsp_row_count,
   output logic [47:0] rsp_row_shallow,
   output logic [47:0] rsp_row_native,
   output logic        rsp_overflow_seen,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);
   import gbka_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   state_type              state_ff, state_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   dropped_ff, dropped_in;
   logic [1:0]             mode_ff, mode_in;
   logic [5:0]             report_ff, report_in;
   cmd_type                cmd_ff, cmd_in;
   logic [31:0]            key_ff, key_in;
   logic [31:0]            amt_ff, amt_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   live_ff, live_in;
   logic [IDX_W-1:0]       raddr_ff, raddr_in;
   logic                   free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [31:0]            tc_ff, tc_in;
   logic [47:0]            ts_ff, ts_in;
   logic [47:0]            tn_ff, tn_in;
   logic [CNT_W-1:0]       nvalid_ff, nvalid_in;
   logic [5:0]             nrank_ff, nrank_in;
   logic [5:0]             rank_ff, rank_in;
   logic                   best_ok_ff, best_ok_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   entry_type              best_ff, best_in;

   logic             issue;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [ENTRY_W-1:0] rd_bits;
   entry_type        rd_entry;
   logic             hit_valid;
   logic             last_beat;
   logic             out_free;
   logic             out_load;
   row_type          out_row;
   row_type          rsp_row;
   logic [5:0]       cap;
   logic [47:0]      m_cur, m_best;

   gbka_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_bits)
   );

   gbka_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .row       (out_row),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_row   (rsp_row)
   );

   assign rd_entry  = entry_type'(rd_bits);
   assign hit_valid = live_ff && valid_ff[raddr_ff];
   assign last_beat = live_ff && (raddr_ff == LAST_IDX);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_row_kind      = rsp_row.kind;
   assign rsp_row_key       = rsp_row.key;
   assign rsp_row_count     = rsp_row.count;
   assign rsp_row_shallow   = rsp_row.shallow;
   assign rsp_row_native    = rsp_row.native;
   assign rsp_overflow_seen = rsp_row.overflow;
   assign rsp_last          = rsp_row.last;

   // ranking metric of the entry on the read port and of the current best
   always_comb begin
      unique case (order_type'(mode_ff))
         ORDER_COUNT: begin
            m_cur  = {16'd0, rd_entry.count};
            m_best = {16'd0, best_ff.count};
         end
         ORDER_SHALLOW: begin
            m_cur  = rd_entry.shallow;
            m_best = best_ff.shallow;
         end
         default: begin
            m_cur  = rd_entry.native;
            m_best = best_ff.native;
         end
      endcase
   end

   // rows to rank in this report
   always_comb begin
      if (order_type'(mode_ff) == ORDER_NONE) begin
         cap = 6'd0;
      end else if (32'(nvalid_ff) < 32'(report_ff)) begin
         cap = 6'(nvalid_ff);
      end else begin
         cap = report_ff;
      end
   end

   // next state and datapath
   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      dropped_in  = dropped_ff;
      mode_in     = mode_ff;
      report_in   = report_ff;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      amt_in      = amt_ff;
      scan_in     = scan_ff;
      live_in     = 1'b0;
      raddr_in    = raddr_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      tc_in       = tc_ff;
      ts_in       = ts_ff;
      tn_in       = tn_ff;
      nvalid_in   = nvalid_ff;
      nrank_in    = nrank_ff;
      rank_in     = rank_ff;
      best_ok_in  = best_ok_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      issue       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = free_idx_ff;
      wr_entry    = rd_entry;
      out_load    = 1'b0;
      out_row     = '0;

      // register writes
      if (csr_valid) begin
         if (csr_index == REG_ORDER_MODE) begin
            mode_in = csr_data[1:0];
         end else if (csr_index == REG_REPORT_COUNT) begin
            report_in = csr_data[5:0];
         end
      end

      // issue one read a cycle during a scan
      if (state_ff == ST_REC_SCAN || state_ff == ST_TOT_SCAN || state_ff == ST_RANK_SCAN) begin
         issue = (scan_ff < CNT_W'(TABLE_DEPTH));
         if (issue) begin
            scan_in  = scan_ff + CNT_W'(1);
            live_in  = 1'b1;
            raddr_in = scan_ff[IDX_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = cmd_type'(req_command);
               key_in      = req_class_key;
               amt_in      = req_amount;
               scan_in     = '0;
               free_ok_in  = 1'b0;
               tc_in       = '0;
               ts_in       = '0;
               tn_in       = '0;
               nvalid_in   = '0;
               priority case (cmd_type'(req_command))
                  CMD_OBJECT, CMD_NATIVE: begin
                     if (req_class_key != 32'd0) begin
                        state_in = ST_REC_SCAN;
                     end
                  end
                  CMD_REPORT: state_in = ST_TOT_SCAN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end

         ST_REC_SCAN: begin
            // note the first free slot at issue
            if (issue && !free_ok_ff && !valid_ff[scan_ff[IDX_W-1:0]]) begin
               free_ok_in  = 1'b1;
               free_idx_in = scan_ff[IDX_W-1:0];
            end
            if (hit_valid && rd_entry.key == key_ff) begin
               // update in place
               wr_en   = 1'b1;
               wr_addr = raddr_ff;
               if (cmd_ff == CMD_NATIVE) begin
                  wr_entry.native = sat48(rd_entry.native, {16'd0, amt_ff});
               end else begin
                  wr_entry.count   = sat32(rd_entry.count, 32'd1);
                  wr_entry.shallow = sat48(rd_entry.shallow, {16'd0, amt_ff});
               end
               state_in = ST_IDLE;
            end else if (last_beat) begin
               if (cmd_ff == CMD_OBJECT) begin
                  if (free_ok_ff) begin
                     wr_en            = 1'b1;
                     wr_addr          = free_idx_ff;
                     wr_entry.key     = key_ff;
                     wr_entry.count   = 32'd1;
                     wr_entry.shallow = {16'd0, amt_ff};
                     wr_entry.native  = '0;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end

         ST_TOT_SCAN: begin
            // accumulate totals over valid entries
            if (hit_valid) begin
               tc_in     = sat32(tc_ff, rd_entry.count);
               ts_in     = sat48(ts_ff, rd_entry.shallow);
               tn_in     = sat48(tn_ff, rd_entry.native);
               nvalid_in = nvalid_ff + CNT_W'(1);
            end
            if (last_beat) begin
               state_in = ST_TOT_EMIT;
            end
         end

         ST_TOT_EMIT: begin
            if (out_free) begin
               out_load         = 1'b1;
               out_row.kind     = 1'b0;
               out_row.count    = tc_ff;
               out_row.shallow  = ts_ff;
               out_row.native   = tn_ff;
               out_row.overflow = dropped_ff;
               out_row.last     = (cap == 6'd0);
               nrank_in         = cap;
               rank_in          = '0;
               scan_in          = '0;
               best_ok_in       = 1'b0;
               if (cap == 6'd0) begin
                  valid_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_RANK_SCAN;
               end
            end
         end

         ST_RANK_SCAN: begin
            // keep the largest metric, larger key on ties
            if (hit_valid) begin
               if (!best_ok_ff || m_cur > m_best ||
                   (m_cur == m_best && rd_entry.key > best_ff.key)) begin
                  best_ok_in  = 1'b1;
                  best_idx_in = raddr_ff;
                  best_in     = rd_entry;
               end
            end
            if (last_beat) begin
               state_in = ST_RANK_EMIT;
            end
         end

         ST_RANK_EMIT: begin
            if (out_free) begin
               out_load         = 1'b1;
               out_row.kind     = 1'b1;
               out_row.key      = best_ff.key;
               out_row.count    = best_ff.count;
               out_row.shallow  = best_ff.shallow;
               out_row.native   = best_ff.native;
               out_row.overflow = dropped_ff;
               out_row.last     = (rank_ff + 6'd1 == nrank_ff);
               valid_in[best_idx_ff] = 1'b0;
               rank_in          = rank_ff + 6'd1;
               scan_in          = '0;
               best_ok_in       = 1'b0;
               if (rank_ff + 6'd1 == nrank_ff) begin
                  valid_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_RANK_SCAN;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         dropped_ff <= 1'b0;
         mode_ff    <= ORDER_COUNT;
         report_ff  <= 6'd10;
         live_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         dropped_ff <= dropped_in;
         mode_ff    <= mode_in;
         report_ff  <= report_in;
         live_ff    <= live_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      amt_ff      <= amt_in;
      scan_ff     <= scan_in;
      raddr_ff    <= raddr_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      tc_ff       <= tc_in;
      ts_ff       <= ts_in;
      tn_ff       <= tn_in;
      nvalid_ff   <= nvalid_in;
      nrank_ff    <= nrank_in;
      rank_ff     <= rank_in;
      best_ok_ff  <= best_ok_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
   end

endmodule

FILE: rtl/gbka_ram.sv
module gbka_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 160,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/gbka_rsp_reg.sv
module gbka_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  gbka_pkg::row_type row,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gbka_pkg::row_type rsp_row
);
   import gbka_pkg::*;

   logic    valid_ff, valid_in;
   row_type row_ff, row_in;

   assign free = !valid_ff || rsp_ready;

   // hold a beat until taken, refill in the same cycle
   always_comb begin
      valid_in = valid_ff;
      row_in   = row_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         row_in   = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      row_ff <= row_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_row   = row_ff;

endmodule

FILE: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gbka_pkg::*;

   localparam int         CYCLE_LIMIT = 2_000_000;
   localparam int         SETTLE      = TABLE_DEPTH + 40;
   localparam logic [7:0] REG_UNUSED  = 8'd5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid, req_ready;
   logic [1:0]  req_command;
   logic [31:0] req_class_key, req_amount;
   logic        rsp_valid, rsp_ready;
   logic        rsp_row_kind, rsp_overflow_seen, rsp_last;
   logic [31:0] rsp_row_key, rsp_row_count;
   logic [47:0] rsp_row_shallow, rsp_row_native;
   logic        csr_valid, csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_data;

   group_by_key_aggregate_top_n u_dut (.*);

   always #6 clock = ~clock;

   // shadow copy of the aggregate table and registers
   logic        agg_valid   [TABLE_DEPTH];
   logic [31:0] agg_key     [TABLE_DEPTH];
   logic [31:0] agg_count   [TABLE_DEPTH];
   logic [47:0] agg_shallow [TABLE_DEPTH];
   logic [47:0] agg_native  [TABLE_DEPTH];
   logic        agg_dropped;
   order_type   rank_order;
   logic [5:0]  rank_limit;

   row_type     pending_rows[$];
   int          cycle_cnt   = 0;
   int          hold_end    = 0;
   int          snd_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          errors      = 0;
   int          rows_seen   = 0;
   int          items_sent  = 0;
   int          reports_sent = 0;
   logic [31:0] key_pool[16];

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? MAX48 : s[47:0];
   endfunction

   function automatic logic [47:0] rank_metric(input int i);
      case (rank_order)
         ORDER_COUNT:   return {16'd0, agg_count[i]};
         ORDER_SHALLOW: return agg_shallow[i];
         default:       return agg_native[i];
      endcase
   endfunction

   // append one expected row behind the ones already waiting
   function automatic void expect_row(input row_type r);
      pending_rows = {pending_rows, r};
   endfunction

   // apply one accepted command to the shadow table, queue the rows it yields
   function automatic void aggregate_item(input cmd_type cmd, input logic [31:0] key,
                                          input logic [31:0] amt);
      int          hit, free_slot, nvalid, nrank, best;
      logic [32:0] c33;
      logic [47:0] tc, ts, tn;
      row_type     row;
      hit = -1;
      free_slot = -1;
      nvalid = 0;
      tc = '0; ts = '0; tn = '0;
      if (cmd == CMD_OBJECT || cmd == CMD_NATIVE) begin
         if (key == 0) return;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (agg_valid[i] && agg_key[i] == key && hit < 0) hit = i;
            if (!agg_valid[i] && free_slot < 0) free_slot = i;
         end
         if (cmd == CMD_NATIVE) begin
            if (hit >= 0) agg_native[hit] = sat_add48(agg_native[hit], {16'd0, amt});
         end else if (hit >= 0) begin
            agg_count[hit] = (agg_count[hit] == MAX32) ? MAX32 : agg_count[hit] + 1;
            agg_shallow[hit] = sat_add48(agg_shallow[hit], {16'd0, amt});
         end else if (free_slot >= 0) begin
            agg_valid[free_slot]   = 1'b1;
            agg_key[free_slot]     = key;
            agg_count[free_slot]   = 32'd1;
            agg_shallow[free_slot] = {16'd0, amt};
            agg_native[free_slot]  = '0;
         end else begin
            agg_dropped = 1'b1;
         end
         return;
      end
      if (cmd != CMD_REPORT) return;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (agg_valid[i]) begin
            nvalid++;
            c33 = {1'b0, tc[31:0]} + {1'b0, agg_count[i]};
            tc = {16'd0, c33[32] ? MAX32 : c33[31:0]};
            ts = sat_add48(ts, agg_shallow[i]);
            tn = sat_add48(tn, agg_native[i]);
         end
      end
      nrank = (rank_order == ORDER_NONE) ? 0 : ((rank_limit < nvalid) ? rank_limit : nvalid);
      row = '{kind: 1'b0, key: '0, count: tc[31:0], shallow: ts, native: tn,
              overflow: agg_dropped, last: (nrank == 0)};
      expect_row(row);
      for (int k = 1; k <= nrank; k++) begin
         best = -1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!agg_valid[i]) continue;
            if (best < 0 || rank_metric(i) > rank_metric(best) ||
                (rank_metric(i) == rank_metric(best) && agg_key[i] > agg_key[best]))
               best = i;
         end
         row = '{kind: 1'b1, key: agg_key[best], count: agg_count[best],
                 shallow: agg_shallow[best], native: agg_native[best],
                 overflow: agg_dropped, last: (k == nrank)};
         expect_row(row);
         agg_valid[best] = 1'b0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) agg_valid[i] = 1'b0;
      agg_dropped = 1'b0;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d rows outstanding", $time, pending_rows.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off window
   always @(posedge clock) begin
      if (reset || cycle_cnt < hold_end) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // compare each accepted row with the oldest expected row
   always @(posedge clock) begin
      row_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{kind: rsp_row_kind, key: rsp_row_key, count: rsp_row_count,
                 shallow: rsp_row_shallow, native: rsp_row_native,
                 overflow: rsp_overflow_seen, last: rsp_last};
         rows_seen++;
         if (pending_rows.size() == 0) begin
            $display("%0t unexpected row: %p", $time, got);
            errors++;
         end else begin
            want = pending_rows.pop_front();
            if (got.kind != want.kind)
               $display("%0t row_kind exp %0d got %0d", $time, want.kind, got.kind);
            if (got.key != want.key)
               $display("%0t row_key exp %h got %h", $time, want.key, got.key);
            if (got.count != want.count)
               $display("%0t row_count exp %0d got %0d", $time, want.count, got.count);
            if (got.shallow != want.shallow)
               $display("%0t row_shallow exp %0d got %0d", $time, want.shallow, got.shallow);
            if (got.native != want.native)
               $display("%0t row_native exp %0d got %0d", $time, want.native, got.native);
            if (got.overflow != want.overflow)
               $display("%0t overflow_seen exp %0d got %0d", $time, want.overflow,
                        got.overflow);
            if (got.last != want.last)
               $display("%0t last exp %0d got %0d", $time, want.last, got.last);
            if (got != want) errors++;
         end
      end
   end

   // offer one beat; valid is left high so back-to-back beats need no toggle
   task automatic send_item(input cmd_type cmd, input logic [31:0] key,
                            input logic [31:0] amt);
      int gap;
      gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_class_key <= key;
      req_amount    <= amt;
      do @(posedge clock); while (!req_ready);
      aggregate_item(cmd, key, amt);
      items_sent++;
      if (cmd == CMD_REPORT) reports_sent++;
   endtask

   // drop valid, wait out all rows, then let a record scan finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_ORDER_MODE) rank_order = order_type'(data[1:0]);
      else if (idx == REG_REPORT_COUNT) rank_limit = data[5:0];
      @(posedge clock);
   endtask

   // extremes, ignored records, every command and every ranking metric
   task automatic test_directed();
      send_item(CMD_REPORT, 32'd0, 32'd0);
      send_item(CMD_OBJECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_OBJECT, 32'd1, 32'd0);
      send_item(CMD_OBJECT, 32'd0, 32'd77);
      send_item(CMD_NATIVE, 32'd0, 32'd5);
      send_item(CMD_NATIVE, 32'h1234_5678, 32'd9);
      send_item(CMD_NATIVE, 32'd1, 32'hFFFF_FFFF);
      send_item(CMD_OBJECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_OBJECT, 32'd1, 32'd3);
      send_item(CMD_OBJECT, 32'd2, 32'd3);
      send_item(CMD_NONE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_item(CMD_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      foreach (key_pool[m]) if (m < 4) begin
         drain();
         write_reg(REG_ORDER_MODE, m);
         send_item(CMD_OBJECT, 32'd7, 32'd100);
         send_item(CMD_OBJECT, 32'd9, 32'd100);
         send_item(CMD_NATIVE, 32'd7, 32'd50);
         send_item(CMD_REPORT, 32'd0, 32'd0);
      end
      drain();
      write_reg(REG_ORDER_MODE, 32'hFFFF_FFFC);
      write_reg(REG_REPORT_COUNT, 32'd0);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_item(CMD_OBJECT, 32'd3, 32'd1);
      send_item(CMD_REPORT, 32'd0, 32'd0);
      drain();
   endtask

   // fill every slot, overflow on one more key, rank 63 rows (the most a report gives) with many ties
   task automatic test_table_full();
      write_reg(REG_REPORT_COUNT, 32'hFFFF_FFFF);
      for (int i = 1; i <= TABLE_DEPTH; i++) send_item(CMD_OBJECT, i, $urandom);
      send_item(CMD_OBJECT, 32'hDEAD_0001, 32'd1);
      send_item(CMD_OBJECT, 32'd5, 32'd1);
      send_item(CMD_NATIVE, 32'd200, 32'd12);
      send_item(CMD_REPORT, 32'd0, 32'd0);
      send_item(CMD_REPORT, 32'd0, 32'd0);
      drain();
   endtask

   // stall the receiver long enough that a big report backs up the input
   task automatic test_backpressure();
      write_reg(REG_ORDER_MODE, 32'(ORDER_SHALLOW));
      write_reg(REG_REPORT_COUNT, 32'd20);
      for (int i = 0; i < 12; i++) send_item(CMD_OBJECT, $urandom_range(1, 40), $urandom);
      hold_end = cycle_cnt + 3000;
      send_item(CMD_REPORT, 32'd0, 32'd0);
      send_item(CMD_OBJECT, 32'd11, 32'd11);
      send_item(CMD_REPORT, 32'd0, 32'd0);
      drain();
   endtask

   // random mix over a small key pool so records mostly hit known keys
   task automatic test_random(input int n_items, input int snd_pct, input int rcv_pct);
      int      pick;
      cmd_type cmd;
      logic [31:0] key;
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      write_reg(REG_ORDER_MODE, $urandom_range(0, 3));
      write_reg(REG_REPORT_COUNT, $urandom_range(0, 12));
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'd0;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         cmd = (pick < 58) ? CMD_OBJECT : (pick < 85) ? CMD_NATIVE :
               (pick < 95) ? CMD_REPORT : CMD_NONE;
         key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(15)];
         send_item(cmd, key, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4096));
         // pause the sender until every row has come back
         if (n == n_items / 2) drain();
      end
      send_item(CMD_REPORT, 32'd0, 32'd0);
      drain();
   endtask

   initial begin
      req_valid     <= 1'b0;
      req_command   <= CMD_NONE;
      req_class_key <= '0;
      req_amount    <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) agg_valid[i] = 1'b0;
      agg_dropped = 1'b0;
      rank_order  = ORDER_COUNT;
      rank_limit  = 6'd10;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE) @(posedge clock);

      test_directed();
      test_table_full();
      test_backpressure();
      test_random(16, 32, 70);
      test_random(16, 70, 32);
      test_random(16, 0, 0);

      $display("Covered %0d items, %0d reports, %0d rows: all metrics, tie breaks,",
               items_sent, reports_sent, rows_seen);
      $display("ignored records, full table with overflow, long output stall.");
      if (errors == 0 && pending_rows.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
